### hdl/expression_token_lexer_assert.svh
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define ETL_ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("etl: assertion failed");

// next-cycle implication
`define ETL_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("etl: assertion failed");

`endif

### hdl/etl_pkg.sv
package etl_pkg;

   localparam int TOKEN_W     = 16;
   localparam int CHAR_W      = 8;
   localparam int KIND_W      = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NUMBER = 2'd1,
      MODE_IDENT  = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INVALID = 5'd0,
      KIND_END     = 5'd1,
      KIND_LPAREN  = 5'd2,
      KIND_RPAREN  = 5'd3,
      KIND_STAR    = 5'd4,
      KIND_MINUS   = 5'd5,
      KIND_PLUS    = 5'd6,
      KIND_SLASH   = 5'd7,
      KIND_PERCENT = 5'd8,
      KIND_BAR     = 5'd9,
      KIND_AMP     = 5'd10,
      KIND_CARET   = 5'd11,
      KIND_EQUAL   = 5'd12,
      KIND_SEMI    = 5'd13,
      KIND_TILDE   = 5'd14,
      KIND_LESS    = 5'd15,
      KIND_GREATER = 5'd16,
      KIND_NUMBER  = 5'd17,
      KIND_IDENT   = 5'd18
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [TOKEN_W-1:0]   start;
      logic [TOKEN_W-1:0]   length;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic is_zero;
      logic is_space;
      logic is_digit;
      logic is_word;
      logic is_dot;
      logic is_f;
      kind_type op_kind;
   } char_class_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] fill;
      logic                   room;
   } queue_status_type;

   function automatic kind_type op_kind(input logic [CHAR_W-1:0] c);
      kind_type k;
      unique case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h2A:   k = KIND_STAR;
         8'h2D:   k = KIND_MINUS;
         8'h2B:   k = KIND_PLUS;
         8'h2F:   k = KIND_SLASH;
         8'h25:   k = KIND_PERCENT;
         8'h7C:   k = KIND_BAR;
         8'h26:   k = KIND_AMP;
         8'h5E:   k = KIND_CARET;
         8'h3D:   k = KIND_EQUAL;
         8'h3B:   k = KIND_SEMI;
         8'h7E:   k = KIND_TILDE;
         8'h3C:   k = KIND_LESS;
         8'h3E:   k = KIND_GREATER;
         default: k = KIND_INVALID;
      endcase
      return k;
   endfunction

endpackage

### hdl/etl_decode.sv
module etl_decode import etl_pkg::*; (
   input  logic [CHAR_W-1:0] char_code,
   output char_class_type    char_class
);

   logic is_alpha;

   assign is_alpha = (char_code >= 8'h61 && char_code <= 8'h7A) ||
                     (char_code >= 8'h41 && char_code <= 8'h5A);

   always_comb begin
      char_class.is_zero  = (char_code == CHAR_NUL);
      char_class.is_space = (char_code == 8'h20) || (char_code == 8'h09) ||
                            (char_code == 8'h0D) || (char_code == 8'h0A);
      char_class.is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
      char_class.is_word  = is_alpha || (char_code == CHAR_UNDER);
      char_class.is_dot   = (char_code == CHAR_DOT);
      char_class.is_f     = (char_code == CHAR_F);
      char_class.op_kind  = op_kind(char_code);
   end

endmodule

### hdl/etl_step.sv
module etl_step import etl_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char_code,
   input  queue_status_type  status,
   output push_type          push
);

   logic                   in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]      char_ff;
   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] len_ff, len_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   char_class_type cls;
   logic           consume;
   logic           pending;
   logic           cont;
   logic           byte_emits;
   logic [31:0]    pos_wide;
   logic [31:0]    start_wide;
   logic [31:0]    len_wide;
   result_type     close_res;
   result_type     byte_res;

   etl_decode u_decode (
      .char_code  (char_ff),
      .char_class (cls)
   );

   assign consume     = in_valid_ff && status.room;
   assign req_ready   = !in_valid_ff || consume;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign pending = (mode_ff == MODE_NUMBER) || (mode_ff == MODE_IDENT);

   always_comb begin
      unique case (mode_ff)
         MODE_NUMBER: cont = cls.is_digit || cls.is_dot || cls.is_f;
         MODE_IDENT:  cont = cls.is_word || cls.is_digit;
         default:     cont = 1'b0;
      endcase
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (consume && !(pending && cont)) begin
         if (cls.is_digit) begin
            mode_in = MODE_NUMBER;
         end else if (cls.is_word) begin
            mode_in = MODE_IDENT;
         end else begin
            mode_in = MODE_IDLE;
         end
      end
   end

   // results and counters
   always_comb begin
      pos_wide   = 32'(pos_ff);
      start_wide = 32'(start_ff);
      len_wide   = 32'(len_ff);
      byte_emits = cls.is_zero || !(cls.is_space || cls.is_digit || cls.is_word);

      byte_res.kind   = cls.is_zero ? KIND_END : cls.op_kind;
      byte_res.start  = pos_wide[TOKEN_W-1:0];
      byte_res.length = TOKEN_W'(1);
      byte_res.last   = 1'b1;

      close_res.kind   = (mode_ff == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
      close_res.start  = start_wide[TOKEN_W-1:0];
      close_res.length = len_wide[TOKEN_W-1:0];
      close_res.last   = !byte_emits;

      push.count  = 2'd0;
      push.first  = byte_res;
      push.second = byte_res;

      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;

      if (consume) begin
         pos_in = pos_ff + OFFSET_BITS'(1);
         if (pending && cont) begin
            if (len_ff != {OFFSET_BITS{1'b1}}) begin
               len_in = len_ff + OFFSET_BITS'(1);
            end
         end else begin
            if (pending) begin
               push.first = close_res;
               push.count = byte_emits ? 2'd2 : 2'd1;
            end else begin
               push.count = byte_emits ? 2'd1 : 2'd0;
            end
            if (cls.is_zero) begin
               start_in = '0;
               len_in   = '0;
               pos_in   = '0;
            end else if (cls.is_digit || cls.is_word) begin
               start_in = pos_ff;
               len_in   = OFFSET_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         start_ff    <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         char_ff <= req_char_code;
      end
   end

endmodule

### hdl/etl_rsp_queue.sv
module etl_rsp_queue import etl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   output queue_status_type   status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KIND_W-1:0]  rsp_token_kind,
   output logic [TOKEN_W-1:0] rsp_token_start,
   output logic [TOKEN_W-1:0] rsp_token_length,
   output logic               rsp_last_of_run
);

   result_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic                   pop;
   result_type             head;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (fill_ff != '0);
   assign wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign fill_in   = fill_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

   assign status.fill = fill_ff;
   assign status.room = (fill_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

   assign head             = entries_ff[rd_ptr_ff];
   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

endmodule

### hdl/expression_token_lexer.sv
// Byte-stream lexer for arithmetic expression text. Each req_ beat carries one
// byte; each rsp_ beat carries one token (kind, start offset, length) and
// rsp_last_of_run marks the final token a byte caused. Offsets count from the
// last zero byte, wrap at 2^OFFSET_BITS and are reported in their low 16 bits;
// lengths saturate at 2^OFFSET_BITS - 1. A byte enters an input register, is
// classified and folded into the lexer state once the queue has room, and its
// tokens are written into a four-entry result queue, whose head is the rsp_
// beat. One byte is taken per cycle while the queue has two free entries; a
// byte that closes a pending token and also yields its own token needs two
// rsp_ beats, so the sustained byte rate is set by the single result port and
// by how many tokens each byte yields.
`include "expression_token_lexer_assert.svh"

module expression_token_lexer import etl_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [15:0]        rsp_token_length,
   output logic               rsp_last_of_run
);

   push_type         push;
   queue_status_type status;

   etl_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .status        (status),
      .push          (push)
   );

   etl_rsp_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   `ETL_ASSERT_IMPLIES(a_pair_closes_token, clock, reset, push.count == 2'd2,
      push.first.kind == KIND_NUMBER || push.first.kind == KIND_IDENT)
   `ETL_ASSERT_IMPLIES(a_push_has_room, clock, reset, push.count != 2'd0, status.room)
   `ETL_ASSERT_IMPLIES(a_pair_last_marks, clock, reset, push.count == 2'd2,
      !push.first.last && push.second.last)
   `ETL_ASSERT_NEXT(a_push_fills_queue, clock, reset, push.count != 2'd0,
      status.fill != '0)

endmodule
